// ----- rtl/arcq_pkg.sv -----
// Package with constants, codes and types shared by the arc quadrant rasterizer.
package arcq_pkg;

  localparam int COORD_BITS    = 11;
  localparam int FRACTION_BITS = 10;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [2:0] MODE_MIRROR = 3'd0;
  localparam logic [2:0] MODE_PXNY   = 3'd1;
  localparam logic [2:0] MODE_PXPY   = 3'd2;
  localparam logic [2:0] MODE_NXPY   = 3'd3;
  localparam logic [2:0] MODE_NXNY   = 3'd4;

  localparam logic [1:0] SLOT_PXNY = 2'd0;
  localparam logic [1:0] SLOT_NXNY = 2'd1;
  localparam logic [1:0] SLOT_NXPY = 2'd2;
  localparam logic [1:0] SLOT_PXPY = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

endpackage

// ----- rtl/arc_quadrant_rasterizer.sv -----
// Top level of the arc quadrant rasterizer with its serial divider and pixel sequencer.
//
// A start transaction loads the center, radius, clip row and mode and produces no
// pixels. Each step transaction of an active arc produces the one, two or four pixels
// of the current arc point and advances to the next point. When the advance needs a
// new fixed-point quotient, a shared restoring divider computes a quotient of
// COORD_BITS - 1 + FRACTION_BITS bits and retires one quotient bit per cycle; the
// pixels then follow one per cycle while the output does not stall. A step that needs
// no quotient skips the divider and goes straight to emitting its pixels.
// The block is not ready while a step is at work.
module arc_quadrant_rasterizer #(
  parameter int COORD_BITS    = arcq_pkg::COORD_BITS,
  parameter int FRACTION_BITS = arcq_pkg::FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [COORD_BITS-1:0]        in_center_x,
  input  logic [COORD_BITS-1:0]        in_center_y,
  input  logic [COORD_BITS-2:0]        in_radius,
  input  logic [COORD_BITS-1:0]        in_clip_row,
  input  logic [2:0]                   in_arc_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic signed [COORD_BITS+1:0] out_pixel_y,
  output logic                         out_last_of_point,
  output logic                         out_arc_done
);

  localparam int CW    = COORD_BITS;
  localparam int PW    = COORD_BITS + 2;
  localparam int AW    = COORD_BITS + FRACTION_BITS + 1;
  localparam int NW    = COORD_BITS - 1 + FRACTION_BITS;
  localparam int DW    = COORD_BITS - 1;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRACTION_BITS - 1);

  arcq_pkg::state_t state_r, state_nxt;
  arcq_pkg::phase_t phase_r, phase_nxt;

  logic [CW-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, clip_r, clip_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [CW-1:0] outer_r, outer_nxt, inner_r, inner_nxt;
  logic signed [CW-1:0] prev_r, prev_nxt, saved_r, saved_nxt;
  logic signed [CW-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic                 done_r, done_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]        rem_r, rem_nxt, den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [1:0]           slot_r, slot_nxt, slot_end_r, slot_end_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [PW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                 last_r, last_nxt, odone_r, odone_nxt;

  assign in_ready          = (state_r == arcq_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_last_of_point = last_r;
  assign out_arc_done      = odone_r;

  always_comb begin
    logic signed [CW:0]   cmp_a;
    logic signed [CW:0]   cmp_b;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] x_c;
    logic signed [CW-1:0] y_c;
    logic signed [CW-1:0] num_c;
    logic signed [PW-1:0] upper_diff;
    logic                 upper;
    logic [1:0]           s_start;
    logic [1:0]           s_end;
    arcq_pkg::phase_t     ph_after;
    logic [DW:0]          shifted;
    logic [DW+1:0]        trial;
    logic                 fits;
    logic [NW-1:0]        quo_step;
    logic signed [AW-1:0] q_ext;
    logic signed [AW-1:0] acc_new;
    logic signed [AW-1:0] rnd_full;
    logic signed [PW-1:0] xe;
    logic signed [PW-1:0] ye;
    logic signed [PW-1:0] cxe;
    logic signed [PW-1:0] cye;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    clip_nxt      = clip_r;
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    prev_nxt      = prev_r;
    saved_nxt     = saved_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    done_nxt      = done_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    slot_nxt      = slot_r;
    slot_end_nxt  = slot_end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    odone_nxt     = odone_r;

    cmp_a    = '0;
    cmp_b    = '0;
    dy       = outer_r + CW'(1);
    dx       = saved_r;
    ph_after = phase_r;
    num_c    = '0;

    x_c = (phase_r == arcq_pkg::PH_ONE) ? inner_r : outer_r;
    y_c = (phase_r == arcq_pkg::PH_ONE) ? outer_r : inner_r;

    upper_diff = $signed({2'b00, cy_r}) - $signed({{2{y_c[CW-1]}}, y_c});
    upper      = upper_diff > $signed({2'b00, clip_r});
    case (mode_r)
      arcq_pkg::MODE_PXNY: begin
        s_start = arcq_pkg::SLOT_PXNY;
        s_end   = arcq_pkg::SLOT_PXNY;
      end
      arcq_pkg::MODE_PXPY: begin
        s_start = arcq_pkg::SLOT_PXPY;
        s_end   = arcq_pkg::SLOT_PXPY;
      end
      arcq_pkg::MODE_NXPY: begin
        s_start = arcq_pkg::SLOT_NXPY;
        s_end   = arcq_pkg::SLOT_NXPY;
      end
      arcq_pkg::MODE_NXNY: begin
        s_start = arcq_pkg::SLOT_NXNY;
        s_end   = arcq_pkg::SLOT_NXNY;
      end
      default: begin
        s_start = upper ? arcq_pkg::SLOT_PXNY : arcq_pkg::SLOT_NXPY;
        s_end   = arcq_pkg::SLOT_PXPY;
      end
    endcase

    shifted  = {rem_r, quo_r[NW-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    fits     = !trial[DW+1];
    quo_step = {quo_r[NW-2:0], fits};
    q_ext    = (den_r == '0) ? '0 : $signed(AW'(quo_step));
    acc_new  = neg_r ? (acc_r - q_ext) : (acc_r + q_ext);
    rnd_full = (acc_new + HALF) >>> FRACTION_BITS;

    xe  = $signed({{2{ex_r[CW-1]}}, ex_r});
    ye  = $signed({{2{ey_r[CW-1]}}, ey_r});
    cxe = $signed({2'b00, cx_r});
    cye = $signed({2'b00, cy_r});

    case (state_r)
      arcq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == arcq_pkg::KIND_START) begin
            cx_nxt   = in_center_x;
            cy_nxt   = in_center_y;
            clip_nxt = in_clip_row;
            mode_nxt = in_arc_mode;
            acc_nxt  = $signed(AW'({in_radius, {FRACTION_BITS{1'b0}}}));
            prev_nxt = $signed({1'b0, in_radius});
            if (in_radius != '0) begin
              saved_nxt = $signed({1'b0, in_radius});
              inner_nxt = $signed({1'b0, in_radius});
              outer_nxt = '0;
              phase_nxt = arcq_pkg::PH_ONE;
            end else begin
              saved_nxt = '0;
              inner_nxt = '0;
              outer_nxt = '1;
              phase_nxt = arcq_pkg::PH_TWO;
            end
          end else if (phase_r != arcq_pkg::PH_IDLE) begin
            ex_nxt       = x_c;
            ey_nxt       = y_c;
            slot_nxt     = s_start;
            slot_end_nxt = s_end;
            state_nxt    = arcq_pkg::ST_EMIT;
            if (phase_r == arcq_pkg::PH_ONE) begin
              cmp_a = $signed({inner_r[CW-1], inner_r}) + (CW+1)'(1);
              cmp_b = $signed({prev_r[CW-1], prev_r});
              if (cmp_a < cmp_b) begin
                inner_nxt = inner_r + CW'(1);
              end else begin
                prev_nxt = saved_r;
                if (dy < dx) begin
                  outer_nxt = dy;
                  quo_nxt   = {dy[CW-2:0], {FRACTION_BITS{1'b0}}};
                  den_nxt   = dx[DW-1:0];
                  neg_nxt   = 1'b1;
                  state_nxt = arcq_pkg::ST_DIV;
                end else begin
                  prev_nxt  = dy;
                  acc_nxt   = $signed(AW'({dy[CW-2:0], {FRACTION_BITS{1'b0}}}));
                  outer_nxt = dx - CW'(1);
                  saved_nxt = dy;
                  inner_nxt = dy;
                  ph_after  = arcq_pkg::PH_TWO;
                end
              end
            end else begin
              cmp_a = $signed({inner_r[CW-1], inner_r}) - (CW+1)'(1);
              cmp_b = $signed({prev_r[CW-1], prev_r});
              if (cmp_a > cmp_b) begin
                inner_nxt = inner_r - CW'(1);
              end else begin
                prev_nxt = saved_r;
                if (outer_r < 0) begin
                  ph_after = arcq_pkg::PH_IDLE;
                end else begin
                  num_c     = (outer_r == '0) ? CW'(1) : (outer_r - CW'(1));
                  quo_nxt   = {num_c[CW-2:0], {FRACTION_BITS{1'b0}}};
                  den_nxt   = inner_r[DW-1:0];
                  neg_nxt   = (outer_r == '0);
                  outer_nxt = outer_r - CW'(1);
                  state_nxt = arcq_pkg::ST_DIV;
                end
              end
            end
            phase_nxt = ph_after;
            done_nxt  = (ph_after == arcq_pkg::PH_IDLE);
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(NW);
          end
        end
      end
      arcq_pkg::ST_DIV: begin
        rem_nxt = fits ? trial[DW-1:0] : shifted[DW-1:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          acc_nxt   = acc_new;
          saved_nxt = rnd_full[CW-1:0];
          inner_nxt = rnd_full[CW-1:0];
          state_nxt = arcq_pkg::ST_EMIT;
        end
      end
      arcq_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          px_nxt = (slot_r == arcq_pkg::SLOT_NXNY || slot_r == arcq_pkg::SLOT_NXPY) ?
                   (cxe - xe) : (cxe + xe);
          py_nxt = (slot_r == arcq_pkg::SLOT_PXNY || slot_r == arcq_pkg::SLOT_NXNY) ?
                   (cye - ye) : (cye + ye);
          last_nxt  = (slot_r == slot_end_r);
          odone_nxt = done_r;
          if (slot_r == slot_end_r) begin
            state_nxt = arcq_pkg::ST_IDLE;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = arcq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arcq_pkg::ST_IDLE;
      phase_r     <= arcq_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      clip_r      <= '0;
      mode_r      <= '0;
      acc_r       <= '0;
      outer_r     <= '0;
      inner_r     <= '0;
      prev_r      <= '0;
      saved_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      clip_r      <= clip_nxt;
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      outer_r     <= outer_nxt;
      inner_r     <= inner_nxt;
      prev_r      <= prev_nxt;
      saved_r     <= saved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    done_r     <= done_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    slot_r     <= slot_nxt;
    slot_end_r <= slot_end_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    last_r     <= last_nxt;
    odone_r    <= odone_nxt;
  end

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcq_pkg::ST_DIV) |-> !in_ready)
    else $error("Input accepted while the divider is busy.");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcq_pkg::ST_DIV && den_r != '0 && $past(state_r) == arcq_pkg::ST_DIV)
      |-> (rem_r < den_r))
    else $error("Divider remainder is not below the divisor.");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arcq_pkg::ST_EMIT) |-> (slot_r <= slot_end_r))
    else $error("Pixel slot passed the last slot of the point.");

  a_start_arms_arc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == arcq_pkg::KIND_START)
      |=> (phase_r != arcq_pkg::PH_IDLE))
    else $error("Start transaction left the arc idle.");

endmodule
